FILE: hdl/rlbb_pkg.sv
// shared types, constants and the gamma table for the rgb led breathing blink engine
// used by rlbb_core and rgb_led_breathing_blink; no dependencies
`default_nettype none

package rlbb_pkg;

  localparam int TABLE_SIZE = 100;
  localparam int IDX_W      = 7;
  localparam int DUTY_W     = 7;
  localparam int DUR_W      = 32;
  localparam int COLOR_W    = 4;
  localparam int MASK_W     = 3;

  // duration / 200 done as (duration >> 3) / 25 by reciprocal multiply,
  // exact for every 29-bit operand
  localparam int PRE_SHIFT   = 3;
  localparam int DIV_IN_W    = DUR_W - PRE_SHIFT;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 34;
  localparam int PROD_W      = DIV_IN_W + RECIP_W;
  localparam int PERIOD_W    = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_M = 30'd687194768;

  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(TABLE_SIZE - 1);

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_DUR  = 2'd1,
    STATUS_BAD_COLOR = 2'd2
  } status_t;

  typedef struct packed {
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
    logic              done;
    status_t           status;
  } result_t;

  localparam logic [DUTY_W-1:0] GAMMA [TABLE_SIZE] = '{
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd1,
    7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
    7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,  7'd3,
    7'd3,  7'd3,  7'd3,  7'd4,  7'd4,  7'd4,  7'd4,  7'd5,  7'd5,  7'd5,
    7'd5,  7'd6,  7'd6,  7'd6,  7'd7,  7'd7,  7'd8,  7'd8,  7'd8,  7'd9,
    7'd9,  7'd10, 7'd10, 7'd11, 7'd11, 7'd12, 7'd13, 7'd13, 7'd14, 7'd15,
    7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24,
    7'd25, 7'd26, 7'd28, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd37, 7'd39,
    7'd41, 7'd43, 7'd45, 7'd47, 7'd49, 7'd52, 7'd54, 7'd57, 7'd59, 7'd62,
    7'd65, 7'd69, 7'd72, 7'd75, 7'd79, 7'd83, 7'd87, 7'd91, 7'd95, 7'd100
  };

  function automatic logic [DUTY_W-1:0] gamma_lut(input logic [IDX_W-1:0] idx);
    logic [DUTY_W-1:0] val;
    if (idx < IDX_W'(TABLE_SIZE)) begin
      val = GAMMA[idx];
    end else begin
      val = '0;
    end
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rgb_led_breathing_blink.sv
// rgb led single-blink breathing engine, top level with result register
// depends on rlbb_pkg and rlbb_core
//
// usage: each input transaction carries an action (start, stop or 1 ms tick)
// with duration_ms and color; start uses the last two. every accepted
// transaction yields exactly one result transaction with the red, green and
// blue duty in percent, the blink_done flag and a status code.
// the result is in the output register on the edge after acceptance.
// throughput is one transaction per cycle while the receiver takes each
// result; the whole update, including the divide of the duration by 200
// through a single reciprocal multiplier, fits between the input ports and
// the result register. in_ready stays high while the output register is
// empty or is being emptied, so a stalled receiver holds the result and
// blocks only new input until it takes it.
// reset clears the engine to idle with blink_done set and duties zero, and
// empties the output register; no clearing pass is needed.
`default_nettype none

module rgb_led_breathing_blink (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [1:0]                      action,
  input  wire logic [rlbb_pkg::DUR_W-1:0]      duration_ms,
  input  wire logic [rlbb_pkg::COLOR_W-1:0]    color,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [rlbb_pkg::DUTY_W-1:0]     red_duty,
  output      logic [rlbb_pkg::DUTY_W-1:0]     green_duty,
  output      logic [rlbb_pkg::DUTY_W-1:0]     blue_duty,
  output      logic                            blink_done,
  output      logic [1:0]                      status
);

  logic              accept;
  rlbb_pkg::result_t result;
  rlbb_pkg::result_t result_q;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  rlbb_core u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .action      (action),
    .duration_ms (duration_ms),
    .color       (color),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign red_duty   = result_q.red;
  assign green_duty = result_q.green;
  assign blue_duty  = result_q.blue;
  assign blink_done = result_q.done;
  assign status     = result_q.status;

`ifndef SYNTH
  a_zero_dur_status: assert property (@(posedge clk) disable iff (rst)
    accept && action == rlbb_pkg::ACT_START && duration_ms == '0
    |=> out_valid && status == rlbb_pkg::STATUS_ZERO_DUR)
    else $error("zero duration start not reported");

  a_done_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && blink_done |-> red_duty == '0 && green_duty == '0 && blue_duty == '0)
    else $error("duty nonzero while no blink in progress");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> red_duty <= 7'd100 && green_duty <= 7'd100 && blue_duty <= 7'd100)
    else $error("duty above 100 percent");

  a_stop_dark: assert property (@(posedge clk) disable iff (rst)
    accept && action == rlbb_pkg::ACT_STOP
    |=> red_duty == '0 && green_duty == '0 && blue_duty == '0 && status == '0)
    else $error("stop did not force duties off");
`endif

endmodule

`default_nettype wire

FILE: hdl/rlbb_core.sv
// breathing engine state and combinational next-state update for one transaction
// depends on rlbb_pkg (types, gamma table, divider constants)
`default_nettype none

module rlbb_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic [1:0]                      action,
  input  wire logic [rlbb_pkg::DUR_W-1:0]      duration_ms,
  input  wire logic [rlbb_pkg::COLOR_W-1:0]    color,
  output rlbb_pkg::result_t                    result
);

  logic                            running, running_next;
  logic                            falling, falling_next;
  logic [rlbb_pkg::IDX_W-1:0]      table_index, table_index_next;
  logic [rlbb_pkg::PERIOD_W-1:0]   tick_count, tick_count_next;
  logic [rlbb_pkg::PERIOD_W-1:0]   step_period, step_period_next;
  logic [rlbb_pkg::MASK_W-1:0]     color_mask, color_mask_next;
  logic [rlbb_pkg::DUTY_W-1:0]     current_duty, current_duty_next;
  logic                            done_flag, done_flag_next;

  logic [rlbb_pkg::DIV_IN_W-1:0]   div_in;
  logic [rlbb_pkg::PROD_W-1:0]     prod;
  logic [rlbb_pkg::PERIOD_W-1:0]   period;
  logic [rlbb_pkg::PERIOD_W:0]     tick_inc;
  rlbb_pkg::status_t               status;

  assign div_in   = duration_ms[rlbb_pkg::DUR_W-1:rlbb_pkg::PRE_SHIFT];
  assign prod     = rlbb_pkg::PROD_W'(div_in) * rlbb_pkg::PROD_W'(rlbb_pkg::RECIP_M);
  assign period   = prod[rlbb_pkg::PROD_W-1:rlbb_pkg::RECIP_SHIFT];
  assign tick_inc = {1'b0, tick_count} + (rlbb_pkg::PERIOD_W+1)'(1);

  always_comb begin
    running_next      = running;
    falling_next      = falling;
    table_index_next  = table_index;
    tick_count_next   = tick_count;
    step_period_next  = step_period;
    color_mask_next   = color_mask;
    current_duty_next = current_duty;
    done_flag_next    = done_flag;
    status            = rlbb_pkg::STATUS_OK;
    unique case (action)
      rlbb_pkg::ACT_START: begin
        if (duration_ms == '0) begin
          status = rlbb_pkg::STATUS_ZERO_DUR;
        end else if (color[rlbb_pkg::COLOR_W-1]) begin
          status = rlbb_pkg::STATUS_BAD_COLOR;
        end else begin
          color_mask_next   = color[rlbb_pkg::MASK_W-1:0];
          falling_next      = 1'b0;
          table_index_next  = '0;
          done_flag_next    = 1'b0;
          running_next      = 1'b1;
          tick_count_next   = '0;
          step_period_next  = (period == '0) ? rlbb_pkg::PERIOD_W'(1) : period;
          current_duty_next = '0;
        end
      end
      rlbb_pkg::ACT_STOP: begin
        current_duty_next = '0;
        running_next      = 1'b0;
        tick_count_next   = '0;
      end
      rlbb_pkg::ACT_TICK: begin
        if (running) begin
          if (tick_inc >= {1'b0, step_period}) begin
            tick_count_next   = '0;
            current_duty_next = rlbb_pkg::gamma_lut(table_index);
            if (!falling) begin
              if (table_index < rlbb_pkg::IDX_TOP) begin
                table_index_next = table_index + rlbb_pkg::IDX_W'(1);
              end
              if (table_index >= rlbb_pkg::IDX_TOP - rlbb_pkg::IDX_W'(1)) begin
                falling_next = 1'b1;
              end
            end else begin
              if (table_index > '0) begin
                table_index_next = table_index - rlbb_pkg::IDX_W'(1);
              end
              if (table_index <= rlbb_pkg::IDX_W'(1)) begin
                current_duty_next = '0;
                running_next      = 1'b0;
                falling_next      = 1'b0;
                done_flag_next    = 1'b1;
              end
            end
          end else begin
            tick_count_next = tick_inc[rlbb_pkg::PERIOD_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      falling      <= 1'b0;
      table_index  <= '0;
      tick_count   <= '0;
      step_period  <= rlbb_pkg::PERIOD_W'(1);
      color_mask   <= '0;
      current_duty <= '0;
      done_flag    <= 1'b1;
    end else if (en) begin
      running      <= running_next;
      falling      <= falling_next;
      table_index  <= table_index_next;
      tick_count   <= tick_count_next;
      step_period  <= step_period_next;
      color_mask   <= color_mask_next;
      current_duty <= current_duty_next;
      done_flag    <= done_flag_next;
    end
  end

  always_comb begin
    result.red    = color_mask_next[0] ? current_duty_next : '0;
    result.green  = color_mask_next[1] ? current_duty_next : '0;
    result.blue   = color_mask_next[2] ? current_duty_next : '0;
    result.done   = done_flag_next;
    result.status = status;
  end

endmodule

`default_nettype wire

FILE: bench/tb_rgb_led_breathing_blink.sv
// self-checking testbench for rgb_led_breathing_blink: drives start, stop and tick
// transactions and checks every result against a local prediction of the blink engine
// depends on rlbb_pkg and the rgb_led_breathing_blink rtl
`default_nettype none

module tb_rgb_led_breathing_blink;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NOP     = 2'd3;
  localparam int         CURVE_LEN   = 100;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         RANDOM_ITEMS = 430;

  localparam logic [6:0] BREATH_CURVE [CURVE_LEN] = '{
    7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd1,
    7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd1,
    7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,  7'd3,
    7'd3,  7'd3,  7'd3,  7'd4,  7'd4,  7'd4,  7'd4,  7'd5,  7'd5,  7'd5,
    7'd5,  7'd6,  7'd6,  7'd6,  7'd7,  7'd7,  7'd8,  7'd8,  7'd8,  7'd9,
    7'd9,  7'd10, 7'd10, 7'd11, 7'd11, 7'd12, 7'd13, 7'd13, 7'd14, 7'd15,
    7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24,
    7'd25, 7'd26, 7'd28, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd37, 7'd39,
    7'd41, 7'd43, 7'd45, 7'd47, 7'd49, 7'd52, 7'd54, 7'd57, 7'd59, 7'd62,
    7'd65, 7'd69, 7'd72, 7'd75, 7'd79, 7'd83, 7'd87, 7'd91, 7'd95, 7'd100
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [31:0] duration_ms;
  logic [3:0]  color;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  red_duty;
  logic [6:0]  green_duty;
  logic [6:0]  blue_duty;
  logic        blink_done;
  logic [1:0]  status;

  // predicted engine state
  logic        br_running;
  logic        br_falling;
  logic        br_done;
  logic [6:0]  br_pos;
  logic [6:0]  br_duty;
  logic [31:0] br_ticks;
  logic [31:0] br_period;
  logic [2:0]  br_mask;

  rlbb_pkg::result_t due_leds[$];
  int      mismatches = 0;
  int      live_items = 0;
  int      hold_cycles = 0;
  int      cycle_count = 0;
  bit      src_calm = 1'b0;
  bit      sink_calm = 1'b0;

  rgb_led_breathing_blink u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .duration_ms (duration_ms),
    .color       (color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_duty    (red_duty),
    .green_duty  (green_duty),
    .blue_duty   (blue_duty),
    .blink_done  (blink_done),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rlbb_pkg::result_t breathe_step(input logic [1:0] act,
                                                     input logic [31:0] dur,
                                                     input logic [3:0] col);
    rlbb_pkg::result_t res;
    logic [31:0]       per;
    res.status = rlbb_pkg::STATUS_OK;
    if (act == rlbb_pkg::ACT_START) begin
      if (dur == 32'd0) begin
        res.status = rlbb_pkg::STATUS_ZERO_DUR;
      end else if (col > 4'd7) begin
        res.status = rlbb_pkg::STATUS_BAD_COLOR;
      end else begin
        per        = dur / 32'd200;
        br_mask    = col[2:0];
        br_falling = 1'b0;
        br_pos     = '0;
        br_done    = 1'b0;
        br_running = 1'b1;
        br_ticks   = '0;
        br_period  = (per == 32'd0) ? 32'd1 : per;
        br_duty    = '0;
      end
    end else if (act == rlbb_pkg::ACT_STOP) begin
      br_duty    = '0;
      br_running = 1'b0;
      br_ticks   = '0;
    end else if (act == rlbb_pkg::ACT_TICK && br_running) begin
      if (br_ticks + 32'd1 >= br_period) begin
        br_ticks = '0;
        br_duty  = (br_pos < 7'(CURVE_LEN)) ? BREATH_CURVE[br_pos] : 7'd0;
        if (!br_falling) begin
          if (br_pos < 7'(CURVE_LEN - 1)) br_pos = br_pos + 7'd1;
          if (br_pos >= 7'(CURVE_LEN - 1)) br_falling = 1'b1;
        end else begin
          if (br_pos > 7'd0) br_pos = br_pos - 7'd1;
          // back at the bottom of the curve: blink over
          if (br_pos == 7'd0) begin
            br_duty    = '0;
            br_running = 1'b0;
            br_falling = 1'b0;
            br_done    = 1'b1;
          end
        end
      end else begin
        br_ticks = br_ticks + 32'd1;
      end
    end
    res.red   = br_mask[0] ? br_duty : 7'd0;
    res.green = br_mask[1] ? br_duty : 7'd0;
    res.blue  = br_mask[2] ? br_duty : 7'd0;
    res.done  = br_done;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [31:0] dur,
                           input logic [3:0] col);
    int gap;
    gap = src_calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    duration_ms <= dur;
    color       <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!(act == ACT_NOP || (act == rlbb_pkg::ACT_TICK && !br_running))) live_items++;
    due_leds.push_back(breathe_step(act, dur, col));
  endtask

  task automatic send_noise();
    logic [31:0] dur;
    dur = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
    send_item(2'($urandom_range(0, 3)), dur, 4'($urandom_range(0, 15)));
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_leds.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(rlbb_pkg::ACT_TICK, 32'hFFFF_FFFF, 4'd15);
    send_item(ACT_NOP, 32'h0000_0000, 4'd0);
    send_item(rlbb_pkg::ACT_STOP, 32'd0, 4'd0);
    send_item(rlbb_pkg::ACT_START, 32'd0, 4'd0);
    send_item(rlbb_pkg::ACT_START, 32'd0, 4'd15);
    send_item(rlbb_pkg::ACT_START, 32'd5, 4'd8);
    send_item(rlbb_pkg::ACT_START, 32'hFFFF_FFFF, 4'd15);
    send_item(rlbb_pkg::ACT_START, 32'hFFFF_FFFF, 4'd7);
    repeat (2) send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
    // restart while running with the shortest duration
    send_item(rlbb_pkg::ACT_START, 32'd1, 4'd1);
    repeat (3) send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
    send_item(rlbb_pkg::ACT_START, 32'd0, 4'd3);
    send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
    send_item(rlbb_pkg::ACT_START, 32'd50, 4'd9);
    send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
    send_item(ACT_NOP, 32'hFFFF_FFFF, 4'd15);
    send_item(rlbb_pkg::ACT_STOP, 32'd0, 4'd0);
    send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
    send_item(rlbb_pkg::ACT_START, 32'd199, 4'd2);
    send_item(rlbb_pkg::ACT_START, 32'd200, 4'd4);
    send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
    send_item(rlbb_pkg::ACT_START, 32'd400, 4'd6);
    repeat (2) send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
  endtask

  task automatic test_full_blink();
    send_item(rlbb_pkg::ACT_START, 32'($urandom_range(1, 399)), 4'd7);
    repeat (200) send_item(rlbb_pkg::ACT_TICK, 32'($urandom), 4'($urandom_range(0, 15)));
  endtask

  task automatic test_receiver_hold();
    hold_cycles = 80;
    src_calm    = 1'b1;
    send_item(rlbb_pkg::ACT_START, 32'd450, 4'd5);
    repeat (30) send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
    src_calm = 1'b0;
  endtask

  task automatic test_sender_pause();
    send_item(rlbb_pkg::ACT_START, 32'd3, 4'd3);
    repeat (10) send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
    pause_until_drained();
    send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
    send_item(rlbb_pkg::ACT_STOP, 32'd0, 4'd0);
    repeat (2) send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
    send_item(rlbb_pkg::ACT_START, 32'd600, 4'd7);
    repeat (8) send_item(rlbb_pkg::ACT_TICK, 32'd0, 4'd0);
  endtask

  task automatic test_random_sequences();
    int          stop_at;
    int          n;
    int          r;
    logic [31:0] dur;
    stop_at = live_items + RANDOM_ITEMS;
    while (live_items < stop_at) begin
      src_calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r = $urandom_range(0, 9);
        if (r < 7) dur = 32'($urandom_range(1, 399));
        else if (r < 9) dur = 32'($urandom_range(400, 1200));
        else dur = 32'($urandom);
        send_item(rlbb_pkg::ACT_START, dur, 4'($urandom_range(0, 7)));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(195, 210) : $urandom_range(1, 40);
        repeat (n) begin
          if ($urandom_range(0, 29) == 0) send_noise();
          else send_item(rlbb_pkg::ACT_TICK, 32'($urandom), 4'($urandom_range(0, 15)));
        end
      end else begin
        send_noise();
      end
    end
    src_calm = 1'b0;
  endtask

  // receiver side: random ready, occasional long stalls, forced hold-off on request
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
      if (hold_cycles > 0) begin
        out_ready   <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        r = $urandom_range(0, 99);
        if (sink_calm || r < 60) begin
          out_ready <= 1'b1;
        end else if (r < 97) begin
          out_ready  <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else begin
          out_ready  <= 1'b0;
          stall_left = $urandom_range(8, 40);
        end
      end
    end
  end

  // result check on every output transaction
  always @(posedge clk) begin
    rlbb_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_leds.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: r=%0d g=%0d b=%0d done=%0b status=%0d",
                   red_duty, green_duty, blue_duty, blink_done, status);
        end
        mismatches++;
      end else begin
        want = due_leds.pop_front();
        if (red_duty !== want.red || green_duty !== want.green || blue_duty !== want.blue ||
            blink_done !== want.done || status !== want.status) begin
          if (mismatches < 10) begin
            $display("mismatch: expected r=%0d g=%0d b=%0d done=%0b status=%0d,",
                     want.red, want.green, want.blue, want.done, want.status,
                     " got r=%0d g=%0d b=%0d done=%0b status=%0d",
                     red_duty, green_duty, blue_duty, blink_done, status);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = rlbb_pkg::ACT_START;
    duration_ms = '0;
    color       = '0;
    br_running  = 1'b0;
    br_falling  = 1'b0;
    br_done     = 1'b1;
    br_pos      = '0;
    br_duty     = '0;
    br_ticks    = '0;
    br_period   = 32'd1;
    br_mask     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_blink();
    test_receiver_hold();
    test_sender_pause();
    test_random_sequences();

    pause_until_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && due_leds.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
